FILE: sv/arm_angle_pid_controller_top_macros.svh
`ifndef ARM_ANGLE_PID_CONTROLLER_TOP_MACROS_SVH
`define ARM_ANGLE_PID_CONTROLLER_TOP_MACROS_SVH

// Immediate implication on the same edge.
`define AAPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition on one edge, consequence on the next.
`define AAPC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/aapc_pkg.sv
package aapc_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegTargetAngle   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegDriveNegate   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegGainP         = 3'd2;
    localparam logic [CfgIdxW-1:0] RegGainI         = 3'd3;
    localparam logic [CfgIdxW-1:0] RegGainD         = 3'd4;
    localparam logic [CfgIdxW-1:0] RegIntegralLimit = 3'd5;
    localparam logic [CfgIdxW-1:0] RegTolerance     = 3'd6;

    // reset values
    localparam logic [15:0] RstTargetAngle   = 16'd36000;
    localparam logic        RstDriveNegate   = 1'b0;
    localparam logic [15:0] RstGainP         = 16'd448;
    localparam logic [15:0] RstGainI         = 16'd77;
    localparam logic [15:0] RstGainD         = 16'd38;
    localparam logic [15:0] RstIntegralLimit = 16'd5000;
    localparam logic [15:0] RstTolerance     = 16'd500;

    localparam logic [15:0] UnwrapLimit = 16'd18000;
    localparam logic [15:0] UnwrapAdd   = 16'd36000;
    localparam logic [15:0] IntegMinErr = 16'd250;

    localparam int TotalW = 51;
    // effort caps expressed on the undivided sum (scale 25600)
    localparam logic signed [TotalW-1:0] TotalHiLim = 51'sd1689600;
    localparam logic signed [TotalW-1:0] TotalLoLim = -51'sd3276800;
    // floor(m / 100) = (m * 10486) >> 20 for m < 12800
    localparam logic [13:0] RecipDiv100 = 14'd10486;
    localparam logic signed [7:0] CapHi = 8'sd65;
    localparam logic signed [7:0] SatLo = -8'sd127;

    typedef struct packed {
        logic [15:0] angle_raw;
        logic        restart;
    } t_in_word;

    typedef struct packed {
        logic signed [7:0] drive;
        logic              at_target;
    } t_out_word;

    typedef struct packed {
        logic [15:0] target_angle;
        logic        drive_negate;
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [15:0] integral_limit;
        logic [15:0] tolerance;
    } t_cfg;

    typedef struct packed {
        logic [15:0] err;
        logic        at;
        logic        restart;
    } t_err_word;

    typedef struct packed {
        logic [15:0]        err;
        logic [31:0]        sum;
        logic signed [16:0] deriv;
        logic               at;
    } t_pid_word;

    typedef struct packed {
        logic [6:0] q;
        logic       hi;
        logic       lo;
        logic       neg;
        logic       at;
    } t_mag_word;

endpackage

FILE: sv/aapc_err.sv
module aapc_err (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aapc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  aapc_pkg::t_in_word  i_word,
    output logic                o_stall,
    output logic                o_valid,
    output aapc_pkg::t_err_word o_word,
    input  logic                i_stall
);
    import aapc_pkg::*;

    logic      r_a_valid;
    t_in_word  r_a_word;
    logic      r_b_valid;
    t_err_word r_b_word;
    t_err_word n_b_word;
    logic      en_a;
    logic      en_b;
    logic [15:0] pos;
    logic [15:0] diff;

    assign en_b    = !r_b_valid || !i_stall;
    assign en_a    = !r_a_valid || en_b;
    assign o_stall = !en_a;
    assign o_valid = r_b_valid;
    assign o_word  = r_b_word;

    always_comb begin
        pos = (r_a_word.angle_raw < UnwrapLimit) ? r_a_word.angle_raw + UnwrapAdd
                                                 : r_a_word.angle_raw;
        diff = (pos >= i_cfg.target_angle) ? pos - i_cfg.target_angle
                                           : i_cfg.target_angle - pos;
        // |pos - target| < tol is the same strict band test
        n_b_word.err     = diff;
        n_b_word.at      = diff < i_cfg.tolerance;
        n_b_word.restart = r_a_word.restart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_valid;
            if (en_b) r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) r_a_word <= i_word;
        if (en_b) r_b_word <= n_b_word;
    end

endmodule

FILE: sv/aapc_integ.sv
`include "arm_angle_pid_controller_top_macros.svh"

module aapc_integ (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aapc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  aapc_pkg::t_err_word i_word,
    output logic                o_stall,
    output logic                o_valid,
    output aapc_pkg::t_pid_word o_word,
    input  logic                i_stall
);
    import aapc_pkg::*;

    logic        r_valid;
    t_pid_word   r_word;
    t_pid_word   n_word;
    logic [31:0] r_error_sum;
    logic [15:0] r_last_error;
    logic        r_first;
    logic [31:0] n_error_sum;
    logic [15:0] n_last_error;
    logic        n_first;
    logic        en;
    logic        take;
    logic        clr;
    logic        integ_on;
    logic [31:0] sum0;
    logic [15:0] last0;
    logic [32:0] sum_add;
    logic [31:0] sum_sat;

    assign en      = !r_valid || !i_stall;
    assign take    = en && i_valid;
    assign o_stall = !en;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        // restart always clears; a pending start clears only on a PID step
        clr      = i_word.restart || (!i_word.at && r_first);
        sum0     = clr ? '0 : r_error_sum;
        last0    = clr ? '0 : r_last_error;
        sum_add  = {1'b0, sum0} + {17'd0, i_word.err};
        sum_sat  = sum_add[32] ? '1 : sum_add[31:0];
        integ_on = (i_word.err > IntegMinErr) && (i_word.err < i_cfg.integral_limit);

        if (i_word.at) begin
            n_error_sum  = sum0;
            n_last_error = last0;
            n_first      = r_first;
        end else begin
            n_error_sum  = integ_on ? sum_sat : '0;
            n_last_error = i_word.err;
            n_first      = 1'b0;
        end

        n_word.err   = i_word.err;
        n_word.sum   = n_error_sum;
        n_word.deriv = $signed({1'b0, i_word.err}) - $signed({1'b0, last0});
        n_word.at    = i_word.at;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_error_sum  <= '0;
            r_last_error <= '0;
            r_first      <= 1'b1;
        end else begin
            if (en) r_valid <= i_valid;
            if (take) begin
                r_error_sum  <= n_error_sum;
                r_last_error <= n_last_error;
                r_first      <= n_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_word <= n_word;
    end

    `AAPC_ASSERT_NEXT(a_first_drops, take && !i_word.at, !r_first, "start still pending")
    `AAPC_ASSERT_NEXT(a_sum_clr, take && !i_word.at && !integ_on, r_error_sum == '0, "sum kept")
    `AAPC_ASSERT_NEXT(a_band_first, take && i_word.at, $stable(r_first), "start flag moved")
    `AAPC_ASSERT_NEXT(a_band_sum, take && i_word.at && !clr, $stable(r_error_sum), "sum moved")

endmodule

FILE: sv/aapc_mix.sv
module aapc_mix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aapc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  aapc_pkg::t_pid_word i_word,
    output logic                o_stall,
    output logic                o_valid,
    output aapc_pkg::t_mag_word o_word,
    input  logic                i_stall
);
    import aapc_pkg::*;

    // products
    logic               r_p_valid;
    logic [31:0]        r_prod_p;
    logic [47:0]        r_prod_i;
    logic signed [33:0] r_prod_d;
    logic               r_p_at;
    // weighted sum
    logic                     r_t_valid;
    logic signed [TotalW-1:0] r_total;
    logic                     r_t_at;
    // range flags and scaled magnitude
    logic        r_f_valid;
    logic [13:0] r_m;
    logic        r_f_hi;
    logic        r_f_lo;
    logic        r_f_neg;
    logic        r_f_at;
    // quotient
    logic      r_q_valid;
    t_mag_word r_q_word;

    logic en_p;
    logic en_t;
    logic en_f;
    logic en_q;
    logic signed [TotalW-1:0] n_total;
    logic [TotalW-1:0]        mag;
    logic [27:0]              q_prod;

    assign en_q    = !r_q_valid || !i_stall;
    assign en_f    = !r_f_valid || en_q;
    assign en_t    = !r_t_valid || en_f;
    assign en_p    = !r_p_valid || en_t;
    assign o_stall = !en_p;
    assign o_valid = r_q_valid;
    assign o_word  = r_q_word;

    always_comb begin
        n_total = $signed({3'd0, r_prod_i}) + $signed({19'd0, r_prod_p})
                + $signed({{17{r_prod_d[33]}}, r_prod_d});
        mag     = r_total[TotalW-1] ? TotalW'(-r_total) : TotalW'(r_total);
        // 25600 = 256 * 100: drop eight bits, then divide by 100
        q_prod  = 28'(r_m) * 28'(RecipDiv100);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_t_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_q_valid <= 1'b0;
        end else begin
            if (en_p) r_p_valid <= i_valid;
            if (en_t) r_t_valid <= r_p_valid;
            if (en_f) r_f_valid <= r_t_valid;
            if (en_q) r_q_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p) begin
            r_prod_p <= 32'(i_word.err) * 32'(i_cfg.gain_p);
            r_prod_i <= 48'(i_word.sum) * 48'(i_cfg.gain_i);
            r_prod_d <= 34'(i_word.deriv) * 34'($signed({1'b0, i_cfg.gain_d}));
            r_p_at   <= i_word.at;
        end
        if (en_t) begin
            r_total <= n_total;
            r_t_at  <= r_p_at;
        end
        if (en_f) begin
            r_f_hi  <= r_total >= TotalHiLim;
            r_f_lo  <= r_total <= TotalLoLim;
            r_f_neg <= r_total[TotalW-1];
            r_m     <= mag[21:8];
            r_f_at  <= r_t_at;
        end
        if (en_q) begin
            r_q_word.q   <= q_prod[26:20];
            r_q_word.hi  <= r_f_hi;
            r_q_word.lo  <= r_f_lo;
            r_q_word.neg <= r_f_neg;
            r_q_word.at  <= r_f_at;
        end
    end

endmodule

FILE: sv/arm_angle_pid_controller_top.sv
// Arm angle PID controller. Takes one sensor word per cycle while not stalled and returns one
// result word per input word, in order, through the error, integrator, mix and output stages.
// The rate is set by the integral and last-error registers, which are updated in a single stage
// so that each word sees the state left by the one before. Readings below 180 degrees are
// unwrapped by adding 360 degrees; inside the strict tolerance band the drive is 0 and
// at_target is set. Configuration registers may only be written while no word is in flight.
`include "arm_angle_pid_controller_top_macros.svh"

module arm_angle_pid_controller_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  aapc_pkg::t_in_word                i_in_word,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output aapc_pkg::t_out_word               o_out_word,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_we,
    input  logic [aapc_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [aapc_pkg::CfgDataW-1:0]     i_cfg_data
);
    import aapc_pkg::*;

    t_cfg      r_cfg;
    logic      err_valid;
    t_err_word err_word;
    logic      err_stall;
    logic      pid_valid;
    t_pid_word pid_word;
    logic      pid_stall;
    logic      mag_valid;
    t_mag_word mag_word;
    logic      mag_stall;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;
    logic      en_out;
    logic signed [7:0] mag8;
    logic signed [7:0] eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_angle   <= RstTargetAngle;
            r_cfg.drive_negate   <= RstDriveNegate;
            r_cfg.gain_p         <= RstGainP;
            r_cfg.gain_i         <= RstGainI;
            r_cfg.gain_d         <= RstGainD;
            r_cfg.integral_limit <= RstIntegralLimit;
            r_cfg.tolerance      <= RstTolerance;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegTargetAngle:   r_cfg.target_angle   <= i_cfg_data;
                RegDriveNegate:   r_cfg.drive_negate   <= i_cfg_data[0];
                RegGainP:         r_cfg.gain_p         <= i_cfg_data;
                RegGainI:         r_cfg.gain_i         <= i_cfg_data;
                RegGainD:         r_cfg.gain_d         <= i_cfg_data;
                RegIntegralLimit: r_cfg.integral_limit <= i_cfg_data;
                RegTolerance:     r_cfg.tolerance      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aapc_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_stall (o_in_stall),
        .o_valid (err_valid),
        .o_word  (err_word),
        .i_stall (err_stall)
    );

    aapc_integ u_integ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (err_valid),
        .i_word  (err_word),
        .o_stall (err_stall),
        .o_valid (pid_valid),
        .o_word  (pid_word),
        .i_stall (pid_stall)
    );

    aapc_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (pid_valid),
        .i_word  (pid_word),
        .o_stall (pid_stall),
        .o_valid (mag_valid),
        .o_word  (mag_word),
        .i_stall (mag_stall)
    );

    assign en_out    = !r_out_valid || !i_out_stall;
    assign mag_stall = !en_out;

    always_comb begin
        mag8 = {1'b0, mag_word.q};
        if (mag_word.hi) begin
            eff = CapHi;
        end else if (mag_word.lo) begin
            eff = SatLo;
        end else begin
            eff = mag_word.neg ? -mag8 : mag8;
        end
        n_out_word.at_target = mag_word.at;
        if (mag_word.at) begin
            n_out_word.drive = '0;
        end else begin
            n_out_word.drive = r_cfg.drive_negate ? -eff : eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= mag_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `AAPC_ASSERT(a_band_zero, r_out_word.at_target |-> r_out_word.drive == '0, "drive at target")
    `AAPC_ASSERT(a_drive_range, r_out_valid |-> r_out_word.drive != 8'sh80, "drive out of range")

endmodule
